/* hw/rtl/pqem_pkg.sv */
`default_nettype none
package pqem_pkg;

	localparam int ACT_W = 2;
	localparam int STATUS_W = 3;

	typedef enum logic [ACT_W-1:0] {
		ACT_ADD     = 2'd0,
		ACT_EXTRACT = 2'd1,
		ACT_CLEAR   = 2'd2
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED     = 3'd0,
		ST_EXTRACTED = 3'd1,
		ST_CLEARED   = 3'd2,
		ST_DROPPED   = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef struct packed {
		logic latch;
		logic scan;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_req;
		logic scan_last;
	} dp_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/priority_queue_extract_max.sv */
`default_nettype none
// channel | dir | tdata (low bit up)                                | tuser
// s_*     | in  | job_tag, job_priority                             | action
// m_*     | out | out_tag, out_priority, count, is_full, is_empty   | status
//
// Add, clear and extract on an empty queue skip the search and go from accept to the result.
// Extract with n jobs held searches all n first; the search reads one entry a cycle
// at the head of the store while the held region rotates once round.
// Reset empties the queue and drops any pending result; job stores are not cleared.
// The next item is taken while a result waits; it completes once m_tready frees the slot.
module priority_queue_extract_max #(
	parameter int CAPACITY      = 16,
	parameter int TAG_BITS      = 16,
	parameter int PRIORITY_BITS = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// job_tag, job_priority
	input  wire logic [((TAG_BITS+PRIORITY_BITS+7)/8)*8-1:0] s_tdata,
	// action
	input  wire logic [pqem_pkg::ACT_W-1:0]          s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// out_tag, out_priority, count, is_full, is_empty
	output logic [((TAG_BITS+PRIORITY_BITS+$clog2(CAPACITY+1)+2+7)/8)*8-1:0] m_tdata,
	// status
	output logic [pqem_pkg::STATUS_W-1:0]            m_tuser
);
	import pqem_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int M_DW  = ((TAG_BITS + PRIORITY_BITS + CNT_W + 2 + 7) / 8) * 8;
	localparam int M_FW  = TAG_BITS + PRIORITY_BITS + CNT_W + 2;

	ctl_cmd_t                 cmd;
	dp_sts_t                  sts;
	logic [TAG_BITS-1:0]      out_tag;
	logic [PRIORITY_BITS-1:0] out_priority;
	logic [CNT_W-1:0]         out_count;
	logic                     out_full;
	logic                     out_empty;

	pqem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pqem_dp #(
		.CAPACITY      (CAPACITY),
		.TAG_BITS      (TAG_BITS),
		.PRIORITY_BITS (PRIORITY_BITS),
		.CNT_W         (CNT_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_action    (s_tuser),
		.in_tag       (s_tdata[TAG_BITS-1:0]),
		.in_priority  (s_tdata[TAG_BITS+PRIORITY_BITS-1:TAG_BITS]),
		.out_tag      (out_tag),
		.out_priority (out_priority),
		.out_status   (m_tuser),
		.out_count    (out_count),
		.out_full     (out_full),
		.out_empty    (out_empty)
	);

	assign m_tdata = M_DW'(M_FW'({out_empty, out_full, out_count, out_priority, out_tag}));

endmodule
`default_nettype wire

/* hw/rtl/pqem_ctrl.sv */
`default_nettype none
module pqem_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	input  wire pqem_pkg::dp_sts_t sts,
	output pqem_pkg::ctl_cmd_t     cmd
);
	import pqem_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		FINISH
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   slot_free;

	assign slot_free = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == IDLE);
	assign m_tvalid  = m_tvalid_q;

	always_comb begin
		cmd.latch  = (state_q == IDLE) && s_tvalid;
		cmd.scan   = (state_q == SCAN);
		cmd.commit = (state_q == FINISH) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						state_q <= sts.scan_req ? SCAN : FINISH;
					end
				end
				SCAN: begin
					if (sts.scan_last) begin
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (slot_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/pqem_dp.sv */
`default_nettype none
module pqem_dp #(
	parameter int CAPACITY      = 16,
	parameter int TAG_BITS      = 16,
	parameter int PRIORITY_BITS = 8,
	parameter int CNT_W         = $clog2(CAPACITY + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pqem_pkg::ctl_cmd_t            cmd,
	output pqem_pkg::dp_sts_t                  sts,
	input  wire logic [pqem_pkg::ACT_W-1:0]    in_action,
	input  wire logic [TAG_BITS-1:0]           in_tag,
	input  wire logic [PRIORITY_BITS-1:0]      in_priority,
	output logic [TAG_BITS-1:0]                out_tag,
	output logic [PRIORITY_BITS-1:0]           out_priority,
	output logic [pqem_pkg::STATUS_W-1:0]      out_status,
	output logic [CNT_W-1:0]                   out_count,
	output logic                               out_full,
	output logic                               out_empty
);
	import pqem_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);

	logic [TAG_BITS-1:0]      tag_q [CAPACITY];
	logic [PRIORITY_BITS-1:0] pri_q [CAPACITY];
	logic [CNT_W-1:0]         count_q;

	action_t                  act_q;
	logic [TAG_BITS-1:0]      new_tag_q;
	logic [PRIORITY_BITS-1:0] new_pri_q;
	logic [TAG_BITS-1:0]      best_tag_q;
	logic [PRIORITY_BITS-1:0] best_pri_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic [IDX_W-1:0]         scan_idx_q;

	logic [TAG_BITS-1:0]      out_tag_q;
	logic [PRIORITY_BITS-1:0] out_pri_q;
	status_t                  out_status_q;
	logic [CNT_W-1:0]         out_count_q;
	logic                     out_full_q;
	logic                     out_empty_q;

	logic                     head_better;
	logic                     do_add;
	logic                     do_remove;
	logic [CNT_W-1:0]         nxt_count;
	status_t                  res_status;
	logic [TAG_BITS-1:0]      res_tag;
	logic [PRIORITY_BITS-1:0] res_pri;

	always_comb begin
		sts.scan_req  = (action_t'(in_action) == ACT_EXTRACT) && (count_q != '0);
		sts.scan_last = (CNT_W'(scan_idx_q) + CNT_W'(1)) == count_q;
		head_better   = (scan_idx_q == '0) || (best_pri_q < pri_q[0]);
	end

	always_comb begin
		do_add     = 1'b0;
		do_remove  = 1'b0;
		nxt_count  = count_q;
		res_tag    = '0;
		res_pri    = '0;
		res_status = ST_CLEARED;
		case (act_q)
			ACT_ADD: begin
				if (count_q == CNT_W'(CAPACITY)) begin
					res_status = ST_DROPPED;
				end else begin
					do_add     = 1'b1;
					nxt_count  = count_q + CNT_W'(1);
					res_status = ST_ADDED;
				end
			end
			ACT_EXTRACT: begin
				if (count_q == '0) begin
					res_status = ST_EMPTY;
				end else begin
					do_remove  = 1'b1;
					nxt_count  = count_q - CNT_W'(1);
					res_tag    = best_tag_q;
					res_pri    = best_pri_q;
					res_status = ST_EXTRACTED;
				end
			end
			default: begin
				nxt_count  = '0;
				res_status = ST_CLEARED;
			end
		endcase
	end

	// scan rotates the held region by one so the head is the only read port
	for (genvar g = 0; g < CAPACITY; g++) begin : g_entry
		if (g < CAPACITY - 1) begin : g_mid
			always_ff @(posedge clk) begin
				if (cmd.scan) begin
					if (CNT_W'(g + 1) == count_q) begin
						tag_q[g] <= tag_q[0];
						pri_q[g] <= pri_q[0];
					end else begin
						tag_q[g] <= tag_q[g+1];
						pri_q[g] <= pri_q[g+1];
					end
				end else if (cmd.commit && do_add && CNT_W'(g) == count_q) begin
					tag_q[g] <= new_tag_q;
					pri_q[g] <= new_pri_q;
				end else if (cmd.commit && do_remove && IDX_W'(g) >= best_idx_q) begin
					tag_q[g] <= tag_q[g+1];
					pri_q[g] <= pri_q[g+1];
				end
			end
		end else begin : g_last
			always_ff @(posedge clk) begin
				if (cmd.scan) begin
					if (CNT_W'(g + 1) == count_q) begin
						tag_q[g] <= tag_q[0];
						pri_q[g] <= pri_q[0];
					end
				end else if (cmd.commit && do_add && CNT_W'(g) == count_q) begin
					tag_q[g] <= new_tag_q;
					pri_q[g] <= new_pri_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= nxt_count;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q      <= action_t'(in_action);
			new_tag_q  <= in_tag;
			new_pri_q  <= in_priority;
			scan_idx_q <= '0;
		end
		if (cmd.scan) begin
			scan_idx_q <= scan_idx_q + IDX_W'(1);
			if (head_better) begin
				best_tag_q <= tag_q[0];
				best_pri_q <= pri_q[0];
				best_idx_q <= scan_idx_q;
			end
		end
		if (cmd.commit) begin
			out_tag_q    <= res_tag;
			out_pri_q    <= res_pri;
			out_status_q <= res_status;
			out_count_q  <= nxt_count;
			out_full_q   <= (nxt_count == CNT_W'(CAPACITY));
			out_empty_q  <= (nxt_count == '0);
		end
	end

	assign out_tag      = out_tag_q;
	assign out_priority = out_pri_q;
	assign out_status   = out_status_q;
	assign out_count    = out_count_q;
	assign out_full     = out_full_q;
	assign out_empty    = out_empty_q;

endmodule
`default_nettype wire
